@@ hw/rtl/fr32_pkg.sv @@
package fr32_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned SumW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] SyncReset   = 16'h55aa;
  localparam logic [WordW-1:0] MaxLenReset = 16'hffff;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_WORD   = 2'd0,
    CFG_MAX_LEN     = 2'd1,
    CFG_CK_REQUIRED = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CK_ERR  = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] sync_word;
    logic [WordW-1:0] max_len;
    logic             checksum_required;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] payload_word;
    logic [WordW-1:0] payload_index;
    logic [WordW-1:0] frame_type;
    logic [WordW-1:0] frame_len;
    logic [1:0]       status;
  } out_item_t;

  localparam int unsigned OutW = $bits(out_item_t);

endpackage

@@ hw/rtl/fletcher32_frame_receiver.sv @@
// Frame receiver for a 16-bit word link, checked with a Fletcher-32 sum.
// Input side is a queue: drive link_word_i with push high; the item is taken
// on a clock edge where full is low. Words are dropped until the sync word,
// then TYPE, LEN, LEN payload words and a 32-bit checksum (low half first).
// Result side is a queue: while empty is low the oldest result is on the
// kind_o .. status_o ports; pop high takes it. Each payload word of a frame
// with LEN not above max length gives one result (kind 0); the last checksum
// word gives one status result (kind 1). A result passes from the input queue
// through the parser into the output queue; pop takes it on a clock edge.
// Throughput: one word per cycle while the output queue is not full; each word
// is one accumulate step with the parser's two 32-bit adders; the checksum
// fold is done on the low checksum word, so status is a single 32-bit compare.
// When the result side stalls, the output queue fills, the parser holds and
// the input queue fills behind it until full rises; nothing is lost.
// Reset clears both queues, returns the parser to sync hunt and loads the
// registers with their defaults (sync 0x55aa, max length 0xffff, zero
// checksum accepted). Write registers through cfg_we_i / cfg_idx_i /
// cfg_data_i only while the block is idle.
module fletcher32_frame_receiver #(
  parameter int unsigned IN_DEPTH  = 4,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fr32_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fr32_pkg::WordW-1:0]        cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [fr32_pkg::WordW-1:0]        link_word_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              kind_o,
  output logic [fr32_pkg::WordW-1:0]        payload_word_o,
  output logic [fr32_pkg::WordW-1:0]        payload_index_o,
  output logic [fr32_pkg::WordW-1:0]        frame_type_o,
  output logic [fr32_pkg::WordW-1:0]        frame_len_o,
  output logic [1:0]                        status_o
);

  fr32_pkg::cfg_t              cfg_q, cfg_d;
  fr32_pkg::out_item_t         item, head;
  logic [fr32_pkg::WordW-1:0]  word;
  logic [fr32_pkg::OutW-1:0]   head_bits;
  logic                        word_empty, word_pop, item_push, item_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fr32_pkg::CFG_SYNC_WORD:   cfg_d.sync_word = cfg_data_i;
        fr32_pkg::CFG_MAX_LEN:     cfg_d.max_len = cfg_data_i;
        fr32_pkg::CFG_CK_REQUIRED: cfg_d.checksum_required = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word         <= fr32_pkg::SyncReset;
      cfg_q.max_len           <= fr32_pkg::MaxLenReset;
      cfg_q.checksum_required <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fr32_fifo #(
    .WIDTH(fr32_pkg::WordW),
    .DEPTH(IN_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (link_word_i),
    .full_o  (full),
    .pop_i   (word_pop),
    .rdata_o (word),
    .empty_o (word_empty)
  );

  fr32_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_i       (word),
    .word_valid_i (!word_empty),
    .word_pop_o   (word_pop),
    .item_o       (item),
    .item_push_o  (item_push),
    .item_full_i  (item_full)
  );

  fr32_fifo #(
    .WIDTH(fr32_pkg::OutW),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .wdata_i (item),
    .full_o  (item_full),
    .pop_i   (pop),
    .rdata_o (head_bits),
    .empty_o (empty)
  );

  assign head            = fr32_pkg::out_item_t'(head_bits);
  assign kind_o          = head.kind;
  assign payload_word_o  = head.payload_word;
  assign payload_index_o = head.payload_index;
  assign frame_type_o    = head.frame_type;
  assign frame_len_o     = head.frame_len;
  assign status_o        = head.status;

endmodule

@@ hw/rtl/fr32_fifo.sv @@
module fr32_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/fr32_parser.sv @@
module fr32_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fr32_pkg::cfg_t                      cfg_i,
  input  logic [fr32_pkg::WordW-1:0]          word_i,
  input  logic                                word_valid_i,
  output logic                                word_pop_o,
  output fr32_pkg::out_item_t                 item_o,
  output logic                                item_push_o,
  input  logic                                item_full_i
);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_TYPE = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CKLO = 6'b010000,
    PH_CKHI = 6'b100000
  } phase_e;

  localparam int unsigned WW = fr32_pkg::WordW;
  localparam int unsigned SW = fr32_pkg::SumW;

  phase_e        phase_q, phase_d;
  logic [WW-1:0] type_q, type_d, len_q, len_d, seen_q, seen_d, ck_lo_q, ck_lo_d;
  logic [SW-1:0] first_q, first_d, second_q, second_d, ck_q, ck_d;
  logic          oversize_q, oversize_d;
  logic          fire, emit;
  logic [WW-1:0] seen_next;
  logic [SW-1:0] acc_first, rx;
  logic [SW-1:0] ck_raw;

  function automatic logic [WW-1:0] mod65535(input logic [SW-1:0] x);
    logic [WW:0]   s;
    logic [WW-1:0] t;
    s = {1'b0, x[SW-1:WW]} + {1'b0, x[WW-1:0]};
    t = s[WW-1:0] + {{(WW-1){1'b0}}, s[WW]};
    return (t == {WW{1'b1}}) ? '0 : t;
  endfunction

  assign fire       = word_valid_i && !item_full_i;
  assign word_pop_o = fire;
  assign acc_first  = first_q + {{(SW-WW){1'b0}}, word_i};
  assign seen_next  = seen_q + 1'b1;
  assign rx         = {word_i, ck_lo_q};
  assign ck_raw     = {mod65535(second_q), mod65535(first_q)};

  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    len_d      = len_q;
    seen_d     = seen_q;
    ck_lo_d    = ck_lo_q;
    first_d    = first_q;
    second_d   = second_q;
    ck_d       = ck_q;
    oversize_d = oversize_q;
    emit       = 1'b0;
    item_o               = '0;
    item_o.frame_type    = type_q;
    item_o.frame_len     = len_q;
    if (fire) begin
      case (phase_q)
        PH_TYPE: begin
          type_d   = word_i;
          first_d  = {{(SW-WW){1'b0}}, word_i};
          second_d = {{(SW-WW){1'b0}}, word_i};
          phase_d  = PH_LEN;
        end
        PH_LEN: begin
          len_d      = word_i;
          first_d    = acc_first;
          second_d   = second_q + acc_first;
          oversize_d = (word_i > cfg_i.max_len);
          seen_d     = '0;
          phase_d    = (word_i == '0) ? PH_CKLO : PH_DATA;
        end
        PH_DATA: begin
          first_d  = acc_first;
          second_d = second_q + acc_first;
          seen_d   = seen_next;
          if (seen_next >= len_q) begin
            phase_d = PH_CKLO;
          end
          emit                 = !oversize_q;
          item_o.kind          = fr32_pkg::KIND_PAYLOAD;
          item_o.payload_word  = word_i;
          item_o.payload_index = seen_q;
        end
        PH_CKLO: begin
          ck_lo_d = word_i;
          ck_d    = (ck_raw == '0) ? {SW{1'b1}} : ck_raw;
          phase_d = PH_CKHI;
        end
        PH_CKHI: begin
          emit        = 1'b1;
          item_o.kind = fr32_pkg::KIND_END;
          if (oversize_q) begin
            item_o.status = fr32_pkg::ST_BAD_LEN;
          end else if (rx == '0) begin
            item_o.status = cfg_i.checksum_required ? fr32_pkg::ST_CK_ERR : fr32_pkg::ST_OK;
          end else begin
            item_o.status = (rx == ck_q) ? fr32_pkg::ST_OK : fr32_pkg::ST_CK_ERR;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = (word_i == cfg_i.sync_word) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  assign item_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      type_q     <= '0;
      len_q      <= '0;
      seen_q     <= '0;
      ck_lo_q    <= '0;
      first_q    <= '0;
      second_q   <= '0;
      ck_q       <= '0;
      oversize_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      type_q     <= type_d;
      len_q      <= len_d;
      seen_q     <= seen_d;
      ck_lo_q    <= ck_lo_d;
      first_q    <= first_d;
      second_q   <= second_d;
      ck_q       <= ck_d;
      oversize_q <= oversize_d;
    end
  end

endmodule
